// File: hw/rtl/tcsm_pkg.sv
// ----------------------------------------------------------------------------
// tcsm_pkg: shared types and codes of the TCP connection state machine
// Word layouts, connection states, actions, segment flags and event codes.
// ----------------------------------------------------------------------------
package tcsm_pkg;

    typedef enum logic [3:0] {
        ST_CLOSED     = 4'd0,
        ST_LISTEN     = 4'd1,
        ST_SYN_SENT   = 4'd2,
        ST_SYN_RCVD   = 4'd3,
        ST_ESTAB      = 4'd4,
        ST_FIN_WAIT_1 = 4'd5,
        ST_FIN_WAIT_2 = 4'd6,
        ST_CLOSE_WAIT = 4'd7,
        ST_CLOSING    = 4'd8,
        ST_LAST_ACK   = 4'd9,
        ST_TIME_WAIT  = 4'd10
    } conn_state_t;

    localparam logic [2:0] ACT_SEGMENT = 3'd0;
    localparam logic [2:0] ACT_OPEN    = 3'd1;
    localparam logic [2:0] ACT_LISTEN  = 3'd2;
    localparam logic [2:0] ACT_CLOSE   = 3'd3;
    localparam logic [2:0] ACT_ABORT   = 3'd4;

    localparam logic [5:0] FL_FIN = 6'h01;
    localparam logic [5:0] FL_SYN = 6'h02;
    localparam logic [5:0] FL_RST = 6'h04;
    localparam logic [5:0] FL_ACK = 6'h10;

    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_CONNECTED  = 4'd1;
    localparam logic [3:0] EV_REFUSED    = 4'd2;
    localparam logic [3:0] EV_DISCONNECT = 4'd3;
    localparam logic [3:0] EV_PEER_RESET = 4'd4;
    localparam logic [3:0] EV_RELEASED   = 4'd5;
    localparam logic [3:0] EV_BAD_CSUM   = 4'd6;
    localparam logic [3:0] EV_NO_SPACE   = 4'd7;
    localparam logic [3:0] EV_BAD_SEQ    = 4'd8;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] seg_window;
        logic [15:0] payload_len;
        logic        checksum_ok;
        logic [15:0] rx_space_free;
        logic        rx_pending;
        logic [31:0] initial_seq;
    } item_t;

    typedef struct packed {
        logic        send_valid;
        logic [5:0]  send_flags;
        logic [31:0] send_seq;
        logic [31:0] send_ack;
        logic [3:0]  conn_status;
        logic [3:0]  event_code;
        logic        accept_payload;
        logic [15:0] peer_window_out;
        logic        last_result;
    } result_t;

    typedef struct packed {
        conn_state_t conn;
        logic [31:0] our_iss;
        logic [31:0] snd_nxt;
        logic [31:0] snd_una;
        logic [31:0] rcv_nxt;
        logic [15:0] peer_win;
    } conn_ctx_t;

    typedef struct packed {
        logic [5:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
    } tx_t;

    function automatic tx_t mk_tx(logic [5:0] flags, logic [31:0] seq, logic [31:0] ack);
        tx_t t;
        t.flags = flags;
        t.seq   = seq;
        t.ack   = ((flags & FL_ACK) != 6'd0) ? ack : 32'd0;
        return t;
    endfunction

    function automatic logic seq_lt(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

endpackage

// File: hw/rtl/tcsm_step.sv
// ----------------------------------------------------------------------------
// tcsm_step: one connection step
// Compute the next connection context and up to two result words for a word.
// ----------------------------------------------------------------------------
module tcsm_step (
    input  tcsm_pkg::item_t     item,
    input  tcsm_pkg::conn_ctx_t ctx,
    output tcsm_pkg::conn_ctx_t ctx_next,
    output tcsm_pkg::result_t   res0,
    output tcsm_pkg::result_t   res1
);

    tcsm_pkg::conn_ctx_t c;
    tcsm_pkg::tx_t       tx0;
    tcsm_pkg::tx_t       tx1;
    logic [1:0]          n;
    logic [3:0]          ev;
    logic                acc;

    // next-state logic
    always_comb
    begin
        logic [5:0]  fl;
        logic [5:0]  ef;
        logic        do_est;
        logic        est_rst;
        logic        nospace;
        logic        need_ack;
        logic [31:0] last_una;
        logic        lenz;

        c        = ctx;
        tx0      = '0;
        tx1      = '0;
        n        = 2'd0;
        ev       = tcsm_pkg::EV_NONE;
        acc      = 1'b0;
        fl       = item.seg_flags;
        ef       = fl;
        do_est   = 1'b0;
        est_rst  = 1'b0;
        nospace  = 1'b0;
        need_ack = 1'b0;
        last_una = ctx.snd_una;
        lenz     = (item.payload_len == 16'd0);

        unique case (item.action)
            tcsm_pkg::ACT_SEGMENT:
            begin
                if (!item.checksum_ok)
                begin
                    ev = tcsm_pkg::EV_BAD_CSUM;
                end
                else
                begin
                    unique case (ctx.conn)
                        tcsm_pkg::ST_CLOSED:
                        begin
                            if ((fl & tcsm_pkg::FL_RST) == 6'd0)
                            begin
                                if ((fl & tcsm_pkg::FL_ACK) != 6'd0)
                                    tx0 = tcsm_pkg::mk_tx(tcsm_pkg::FL_RST, item.seg_ack, 32'd0);
                                else
                                    tx0 = tcsm_pkg::mk_tx(tcsm_pkg::FL_RST | tcsm_pkg::FL_ACK,
                                        32'd0, item.seg_seq
                                        + {31'd0, ((fl & tcsm_pkg::FL_SYN) != 6'd0)});
                                n = 2'd1;
                            end
                        end
                        tcsm_pkg::ST_LISTEN:
                        begin
                            if ((fl & tcsm_pkg::FL_RST) == 6'd0
                                && (fl & tcsm_pkg::FL_SYN) != 6'd0)
                            begin
                                c.rcv_nxt  = item.seg_seq + 32'd1;
                                c.peer_win = item.seg_window;
                                c.conn     = tcsm_pkg::ST_SYN_RCVD;
                                tx0 = tcsm_pkg::mk_tx(tcsm_pkg::FL_SYN | tcsm_pkg::FL_ACK,
                                    ctx.our_iss, c.rcv_nxt);
                                n = 2'd1;
                                c.snd_nxt = ctx.our_iss + 32'd1;
                                c.snd_una = ctx.our_iss;
                            end
                        end
                        tcsm_pkg::ST_SYN_SENT:
                        begin
                            if ((fl & tcsm_pkg::FL_RST) != 6'd0)
                            begin
                                c.conn = tcsm_pkg::ST_CLOSED;
                                ev     = tcsm_pkg::EV_REFUSED;
                            end
                            else if ((fl & (tcsm_pkg::FL_SYN | tcsm_pkg::FL_ACK)) != 6'd0)
                            begin
                                if (item.seg_ack != ctx.snd_una + 32'd1)
                                begin
                                    c.conn = tcsm_pkg::ST_CLOSED;
                                    ev     = tcsm_pkg::EV_REFUSED;
                                end
                                else
                                begin
                                    c.rcv_nxt  = item.seg_seq + 32'd1;
                                    c.peer_win = item.seg_window;
                                    c.snd_nxt  = ctx.snd_nxt + 32'd1;
                                    c.snd_una  = ctx.snd_una + 32'd1;
                                    c.conn     = tcsm_pkg::ST_ESTAB;
                                    tx0 = tcsm_pkg::mk_tx(tcsm_pkg::FL_ACK, c.snd_nxt, c.rcv_nxt);
                                    n   = 2'd1;
                                    ev  = tcsm_pkg::EV_CONNECTED;
                                end
                            end
                        end
                        tcsm_pkg::ST_SYN_RCVD:
                        begin
                            if ((fl & tcsm_pkg::FL_RST) != 6'd0)
                            begin
                                c.conn = tcsm_pkg::ST_LISTEN;
                            end
                            else if ((fl & tcsm_pkg::FL_ACK) != 6'd0)
                            begin
                                c.conn = tcsm_pkg::ST_ESTAB;
                                ev     = tcsm_pkg::EV_CONNECTED;
                                do_est = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (ctx.rcv_nxt != item.seg_seq)
                            begin
                                ev = tcsm_pkg::EV_BAD_SEQ;
                                if (ctx.rcv_nxt != item.seg_seq + 32'd1)
                                begin
                                    tx0 = tcsm_pkg::mk_tx(tcsm_pkg::FL_ACK, ctx.snd_nxt,
                                        ctx.rcv_nxt);
                                    n = 2'd1;
                                end
                            end
                            else
                            begin
                                unique case (ctx.conn)
                                    tcsm_pkg::ST_ESTAB, tcsm_pkg::ST_CLOSE_WAIT:
                                        do_est = 1'b1;
                                    tcsm_pkg::ST_FIN_WAIT_1:
                                    begin
                                        if ((fl & tcsm_pkg::FL_FIN) != 6'd0)
                                        begin
                                            c.rcv_nxt = ctx.rcv_nxt + 32'd1;
                                            ef        = fl & ~tcsm_pkg::FL_FIN;
                                            c.conn    = tcsm_pkg::ST_CLOSING;
                                            need_ack  = 1'b1;
                                        end
                                        do_est = 1'b1;
                                    end
                                    tcsm_pkg::ST_FIN_WAIT_2:
                                    begin
                                        if ((fl & tcsm_pkg::FL_FIN) != 6'd0)
                                        begin
                                            c.rcv_nxt = ctx.rcv_nxt + 32'd1;
                                            ef        = fl & ~tcsm_pkg::FL_FIN;
                                            c.conn    = tcsm_pkg::ST_TIME_WAIT;
                                            need_ack  = 1'b1;
                                        end
                                        do_est = 1'b1;
                                    end
                                    tcsm_pkg::ST_CLOSING:
                                    begin
                                        if ((fl & tcsm_pkg::FL_FIN) != 6'd0)
                                        begin
                                            c.rcv_nxt = ctx.rcv_nxt + 32'd1;
                                            ef        = fl & ~tcsm_pkg::FL_FIN;
                                        end
                                        do_est = 1'b1;
                                    end
                                    tcsm_pkg::ST_LAST_ACK:
                                    begin
                                        if ((fl & (tcsm_pkg::FL_ACK | tcsm_pkg::FL_RST)) != 6'd0)
                                        begin
                                            c.conn = tcsm_pkg::ST_CLOSED;
                                            ev     = tcsm_pkg::EV_RELEASED;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    endcase

                    // common synchronized-state processing
                    if (do_est)
                    begin
                        c.peer_win = item.seg_window;
                        if (!lenz)
                        begin
                            if (item.payload_len > item.rx_space_free)
                            begin
                                ev      = tcsm_pkg::EV_NO_SPACE;
                                nospace = 1'b1;
                            end
                            else
                            begin
                                acc = 1'b1;
                            end
                        end
                        if (!nospace)
                        begin
                            if ((ef & tcsm_pkg::FL_ACK) != 6'd0
                                && tcsm_pkg::seq_lt(c.snd_una, item.seg_ack))
                                c.snd_una = item.seg_ack;
                            if ((ef & tcsm_pkg::FL_RST) != 6'd0)
                            begin
                                c.conn  = (c.conn == tcsm_pkg::ST_CLOSE_WAIT)
                                        ? tcsm_pkg::ST_TIME_WAIT : tcsm_pkg::ST_CLOSED;
                                ev      = tcsm_pkg::EV_PEER_RESET;
                                est_rst = 1'b1;
                            end
                            else
                            begin
                                if ((ef & tcsm_pkg::FL_FIN) != 6'd0)
                                begin
                                    c.rcv_nxt = c.rcv_nxt + 32'd1;
                                    c.conn    = tcsm_pkg::ST_CLOSE_WAIT;
                                    if (lenz && !item.rx_pending)
                                        ev = tcsm_pkg::EV_DISCONNECT;
                                end
                                if (!(lenz && ef == tcsm_pkg::FL_ACK))
                                begin
                                    c.rcv_nxt = c.rcv_nxt + {16'd0, item.payload_len};
                                    tx0 = tcsm_pkg::mk_tx(tcsm_pkg::FL_ACK, c.snd_nxt, c.rcv_nxt);
                                    n   = 2'd1;
                                end
                            end
                        end
                        if (!est_rst)
                        begin
                            if (ctx.conn == tcsm_pkg::ST_FIN_WAIT_1
                                && tcsm_pkg::seq_lt(last_una, c.snd_una))
                                c.conn = (c.conn == tcsm_pkg::ST_CLOSING)
                                       ? tcsm_pkg::ST_TIME_WAIT : tcsm_pkg::ST_FIN_WAIT_2;
                            if (ctx.conn == tcsm_pkg::ST_CLOSING
                                && tcsm_pkg::seq_lt(last_una, c.snd_una))
                                c.conn = tcsm_pkg::ST_TIME_WAIT;
                            if (need_ack)
                            begin
                                if (n == 2'd0)
                                    tx0 = tcsm_pkg::mk_tx(tcsm_pkg::FL_ACK, c.snd_nxt, c.rcv_nxt);
                                else
                                    tx1 = tcsm_pkg::mk_tx(tcsm_pkg::FL_ACK, c.snd_nxt, c.rcv_nxt);
                                n = n + 2'd1;
                            end
                        end
                    end
                end
            end
            tcsm_pkg::ACT_OPEN:
            begin
                if (ctx.conn == tcsm_pkg::ST_CLOSED)
                begin
                    c.our_iss = item.initial_seq;
                    c.snd_nxt = item.initial_seq;
                    c.snd_una = item.initial_seq;
                    c.conn    = tcsm_pkg::ST_SYN_SENT;
                    tx0 = tcsm_pkg::mk_tx(tcsm_pkg::FL_SYN, item.initial_seq, ctx.rcv_nxt);
                    n   = 2'd1;
                end
            end
            tcsm_pkg::ACT_LISTEN:
            begin
                if (ctx.conn == tcsm_pkg::ST_CLOSED)
                begin
                    c.our_iss = item.initial_seq;
                    c.conn    = tcsm_pkg::ST_LISTEN;
                end
            end
            tcsm_pkg::ACT_CLOSE:
            begin
                if (ctx.conn == tcsm_pkg::ST_LISTEN || ctx.conn == tcsm_pkg::ST_SYN_SENT)
                begin
                    c.conn = tcsm_pkg::ST_CLOSED;
                    ev     = tcsm_pkg::EV_RELEASED;
                end
                else if (ctx.conn == tcsm_pkg::ST_SYN_RCVD || ctx.conn == tcsm_pkg::ST_ESTAB
                         || ctx.conn == tcsm_pkg::ST_CLOSE_WAIT)
                begin
                    tx0 = tcsm_pkg::mk_tx(tcsm_pkg::FL_FIN | tcsm_pkg::FL_ACK, ctx.snd_nxt,
                        ctx.rcv_nxt);
                    n   = 2'd1;
                    c.snd_nxt = ctx.snd_nxt + 32'd1;
                    c.conn    = (ctx.conn == tcsm_pkg::ST_CLOSE_WAIT)
                              ? tcsm_pkg::ST_LAST_ACK : tcsm_pkg::ST_FIN_WAIT_1;
                end
            end
            tcsm_pkg::ACT_ABORT:
            begin
                if (ctx.conn == tcsm_pkg::ST_SYN_RCVD || ctx.conn == tcsm_pkg::ST_ESTAB
                    || ctx.conn == tcsm_pkg::ST_FIN_WAIT_1
                    || ctx.conn == tcsm_pkg::ST_FIN_WAIT_2
                    || ctx.conn == tcsm_pkg::ST_CLOSE_WAIT)
                begin
                    tx0 = tcsm_pkg::mk_tx(tcsm_pkg::FL_RST, ctx.snd_nxt, 32'd0);
                    n   = 2'd1;
                end
                if (ctx.conn != tcsm_pkg::ST_CLOSED)
                    ev = tcsm_pkg::EV_RELEASED;
                c.conn = tcsm_pkg::ST_CLOSED;
            end
            default: ;
        endcase
    end

    assign ctx_next = c;

    // output words
    always_comb
    begin
        res0.send_valid      = (n != 2'd0);
        res0.send_flags      = tx0.flags;
        res0.send_seq        = tx0.seq;
        res0.send_ack        = tx0.ack;
        res0.conn_status     = c.conn;
        res0.event_code      = ev;
        res0.accept_payload  = acc;
        res0.peer_window_out = c.peer_win;
        res0.last_result     = (n != 2'd2);
        res1                 = res0;
        res1.send_valid      = 1'b1;
        res1.send_flags      = tx1.flags;
        res1.send_seq        = tx1.seq;
        res1.send_ack        = tx1.ack;
        res1.last_result     = 1'b1;
    end

endmodule

// File: hw/rtl/tcp_connection_state_machine.sv
// An accepted item waits in the input register, then its words load into the
// result register. Throughput: one item per cycle when each item yields one
// word and result_ready is high; a two-word item holds the output register
// until both words leave; the single output register pair drains one word per cycle.
// Reset: asynchronous, active low; connection returns to closed, all zero.
// ----------------------------------------------------------------------------
// tcp_connection_state_machine: single TCP connection control
// Input register, one-pass step logic, two-word result register.
// ----------------------------------------------------------------------------
module tcp_connection_state_machine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  tcsm_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_ready,
    output tcsm_pkg::result_t  result
);

    // input stage
    tcsm_pkg::item_t     in_reg;
    logic                in_full_reg;

    // connection context
    tcsm_pkg::conn_ctx_t ctx_reg;
    tcsm_pkg::conn_ctx_t ctx_next;

    // result stage: word 0 is on the port, word 1 waits behind it
    tcsm_pkg::result_t   res0_reg;
    tcsm_pkg::result_t   res1_reg;
    logic                out_full_reg;
    tcsm_pkg::result_t   step_res0;
    tcsm_pkg::result_t   step_res1;

    logic out_take;
    logic out_free;
    logic advance;

    tcsm_step u_step (
        .item     (in_reg),
        .ctx      (ctx_reg),
        .ctx_next (ctx_next),
        .res0     (step_res0),
        .res1     (step_res1)
    );

    assign out_take     = out_full_reg & result_ready;
    // free when empty, or when the last word of the current item leaves now
    assign out_free     = !out_full_reg | (out_take & res0_reg.last_result);
    assign advance      = in_full_reg & out_free;
    assign item_ready   = !in_full_reg | advance;
    assign result_valid = out_full_reg;
    assign result       = res0_reg;

    // hold the accepted word until the step logic consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_reg <= item;
    end

    // commit the connection context as the item advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= '{conn: tcsm_pkg::ST_CLOSED, default: '0};
        end
        else if (advance)
        begin
            ctx_reg <= ctx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_full_reg <= 1'b1;
        end
        else if (out_take && res0_reg.last_result)
        begin
            out_full_reg <= 1'b0;
        end
    end

    // load both words, or shift the waiting word forward
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res0_reg <= step_res0;
            res1_reg <= step_res1;
        end
        else if (out_take && !res0_reg.last_result)
        begin
            res0_reg <= res1_reg;
        end
    end

    a_second_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |=> result_valid)
        else $error("second result word lost");

    a_empty_word_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.send_valid |-> result.last_result)
        else $error("word without segment is not last");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> in_full_reg && result_valid)
        else $error("input stalled with free stages");

endmodule

// File: bench/tcp_connection_state_machine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_connection_state_machine_tb: self-checking bench for the TCP control FSM
// Drives host commands and segment headers, predicts every result word from
// a behavioral model of the connection, and compares field by field.
// ----------------------------------------------------------------------------
module tcp_connection_state_machine_tb;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    tcsm_pkg::item_t   item;
    logic              result_valid;
    logic              result_ready;
    tcsm_pkg::result_t result;

    tcp_connection_state_machine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 120;

    // Connection model state, a copy kept alongside the block.
    tcsm_pkg::conn_state_t m_state;
    logic [31:0] m_iss, m_irs, m_snd_nxt, m_snd_una, m_rcv_nxt;
    logic [15:0] m_win;

    // Per-step scratch.
    int              n_tx;
    logic [5:0]      tx_fl [2];
    logic [31:0]     tx_sq [2];
    logic [31:0]     tx_ak [2];
    logic [3:0]      ev;
    logic            acc;
    tcsm_pkg::item_t cur;

    tcsm_pkg::item_t   pending_items[$];
    tcsm_pkg::result_t expected_words[$];

    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  hold_off = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  errors;
    int  cycles;
    bit  item_ready_seen;

    always #10 clk = ~clk;

    // Sequence compare with wraparound.
    function automatic bit before_seq(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic void push_seg(logic [5:0] fl, logic [31:0] sq, logic [31:0] ak);
        if (n_tx < 2)
        begin
            tx_fl[n_tx] = fl;
            tx_sq[n_tx] = sq;
            tx_ak[n_tx] = ((fl & tcsm_pkg::FL_ACK) != 0) ? ak : 32'd0;
            n_tx++;
        end
    endfunction

    // Shared handling for synchronized states; returns 1 on peer reset.
    function automatic bit sync_rx(logic [5:0] fl);
        m_win = cur.seg_window;
        if (cur.payload_len != 0)
        begin
            if (cur.payload_len > cur.rx_space_free)
            begin
                ev = tcsm_pkg::EV_NO_SPACE;
                return 0;
            end
            acc = 1;
        end
        if ((fl & tcsm_pkg::FL_ACK) != 0 && before_seq(m_snd_una, cur.seg_ack))
            m_snd_una = cur.seg_ack;
        if ((fl & tcsm_pkg::FL_RST) != 0)
        begin
            m_state = (m_state == tcsm_pkg::ST_CLOSE_WAIT) ? tcsm_pkg::ST_TIME_WAIT
                                                           : tcsm_pkg::ST_CLOSED;
            ev = tcsm_pkg::EV_PEER_RESET;
            return 1;
        end
        if ((fl & tcsm_pkg::FL_FIN) != 0)
        begin
            m_rcv_nxt++;
            m_state = tcsm_pkg::ST_CLOSE_WAIT;
            if (cur.payload_len == 0 && !cur.rx_pending)
                ev = tcsm_pkg::EV_DISCONNECT;
        end
        if (cur.payload_len == 0 && fl == tcsm_pkg::FL_ACK)
            return 0;
        m_rcv_nxt += 32'(cur.payload_len);
        push_seg(tcsm_pkg::FL_ACK, m_snd_nxt, m_rcv_nxt);
        return 0;
    endfunction

    task automatic handle_segment();
        logic [5:0]  fl;
        logic [31:0] prev_una;
        bit          need_ack;
        fl = cur.seg_flags;
        need_ack = 0;
        case (m_state)
            tcsm_pkg::ST_CLOSED:
            begin
                if ((fl & tcsm_pkg::FL_RST) == 0)
                begin
                    if ((fl & tcsm_pkg::FL_ACK) != 0)
                        push_seg(tcsm_pkg::FL_RST, cur.seg_ack, 32'd0);
                    else
                        push_seg(tcsm_pkg::FL_RST | tcsm_pkg::FL_ACK, 32'd0,
                                 ((fl & tcsm_pkg::FL_SYN) != 0) ? cur.seg_seq + 1
                                                                : cur.seg_seq);
                end
            end
            tcsm_pkg::ST_LISTEN:
            begin
                if ((fl & tcsm_pkg::FL_RST) == 0 && (fl & tcsm_pkg::FL_SYN) != 0)
                begin
                    m_irs = cur.seg_seq;
                    m_rcv_nxt = cur.seg_seq + 1;
                    m_win = cur.seg_window;
                    m_state = tcsm_pkg::ST_SYN_RCVD;
                    push_seg(tcsm_pkg::FL_SYN | tcsm_pkg::FL_ACK, m_iss, m_rcv_nxt);
                    m_snd_nxt = m_iss + 1;
                    m_snd_una = m_iss;
                end
            end
            tcsm_pkg::ST_SYN_SENT:
            begin
                if ((fl & tcsm_pkg::FL_RST) != 0)
                begin
                    m_state = tcsm_pkg::ST_CLOSED;
                    ev = tcsm_pkg::EV_REFUSED;
                end
                else if ((fl & (tcsm_pkg::FL_SYN | tcsm_pkg::FL_ACK)) != 0)
                begin
                    if (cur.seg_ack != m_snd_una + 1)
                    begin
                        m_state = tcsm_pkg::ST_CLOSED;
                        ev = tcsm_pkg::EV_REFUSED;
                    end
                    else
                    begin
                        m_irs = cur.seg_seq;
                        m_rcv_nxt = cur.seg_seq + 1;
                        m_win = cur.seg_window;
                        m_snd_nxt++;
                        m_snd_una++;
                        m_state = tcsm_pkg::ST_ESTAB;
                        push_seg(tcsm_pkg::FL_ACK, m_snd_nxt, m_rcv_nxt);
                        ev = tcsm_pkg::EV_CONNECTED;
                    end
                end
            end
            tcsm_pkg::ST_SYN_RCVD:
            begin
                if ((fl & tcsm_pkg::FL_RST) != 0)
                    m_state = tcsm_pkg::ST_LISTEN;
                else if ((fl & tcsm_pkg::FL_ACK) != 0)
                begin
                    m_state = tcsm_pkg::ST_ESTAB;
                    ev = tcsm_pkg::EV_CONNECTED;
                    void'(sync_rx(fl));
                end
            end
            default:
            begin
                if (m_rcv_nxt != cur.seg_seq)
                begin
                    ev = tcsm_pkg::EV_BAD_SEQ;
                    if (m_rcv_nxt != cur.seg_seq + 1)
                        push_seg(tcsm_pkg::FL_ACK, m_snd_nxt, m_rcv_nxt);
                end
                else
                begin
                    case (m_state)
                        tcsm_pkg::ST_ESTAB, tcsm_pkg::ST_CLOSE_WAIT: void'(sync_rx(fl));
                        tcsm_pkg::ST_FIN_WAIT_1:
                        begin
                            if ((fl & tcsm_pkg::FL_FIN) != 0)
                            begin
                                m_rcv_nxt++;
                                fl &= ~tcsm_pkg::FL_FIN;
                                m_state = tcsm_pkg::ST_CLOSING;
                                need_ack = 1;
                            end
                            prev_una = m_snd_una;
                            if (!sync_rx(fl))
                            begin
                                if (before_seq(prev_una, m_snd_una))
                                    m_state = (m_state == tcsm_pkg::ST_CLOSING)
                                            ? tcsm_pkg::ST_TIME_WAIT
                                            : tcsm_pkg::ST_FIN_WAIT_2;
                                if (need_ack)
                                    push_seg(tcsm_pkg::FL_ACK, m_snd_nxt, m_rcv_nxt);
                            end
                        end
                        tcsm_pkg::ST_FIN_WAIT_2:
                        begin
                            if ((fl & tcsm_pkg::FL_FIN) != 0)
                            begin
                                m_rcv_nxt++;
                                fl &= ~tcsm_pkg::FL_FIN;
                                m_state = tcsm_pkg::ST_TIME_WAIT;
                                need_ack = 1;
                            end
                            if (!sync_rx(fl) && need_ack)
                                push_seg(tcsm_pkg::FL_ACK, m_snd_nxt, m_rcv_nxt);
                        end
                        tcsm_pkg::ST_CLOSING:
                        begin
                            prev_una = m_snd_una;
                            if ((fl & tcsm_pkg::FL_FIN) != 0)
                            begin
                                m_rcv_nxt++;
                                fl &= ~tcsm_pkg::FL_FIN;
                            end
                            if (!sync_rx(fl) && before_seq(prev_una, m_snd_una))
                                m_state = tcsm_pkg::ST_TIME_WAIT;
                        end
                        tcsm_pkg::ST_LAST_ACK:
                        begin
                            if ((fl & (tcsm_pkg::FL_ACK | tcsm_pkg::FL_RST)) != 0)
                            begin
                                m_state = tcsm_pkg::ST_CLOSED;
                                ev = tcsm_pkg::EV_RELEASED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    endtask

    // Advance the connection model by one word and queue the result words.
    task automatic predict_step(tcsm_pkg::item_t it);
        tcsm_pkg::conn_state_t st;
        tcsm_pkg::result_t     r;
        int                    nres;
        cur = it;
        st = m_state;
        n_tx = 0;
        ev = tcsm_pkg::EV_NONE;
        acc = 0;
        case (it.action)
            tcsm_pkg::ACT_SEGMENT:
            begin
                if (!it.checksum_ok)
                    ev = tcsm_pkg::EV_BAD_CSUM;
                else
                    handle_segment();
            end
            tcsm_pkg::ACT_OPEN:
            begin
                if (st == tcsm_pkg::ST_CLOSED)
                begin
                    m_iss = it.initial_seq;
                    m_snd_nxt = it.initial_seq;
                    m_snd_una = it.initial_seq;
                    m_state = tcsm_pkg::ST_SYN_SENT;
                    push_seg(tcsm_pkg::FL_SYN, m_snd_nxt, m_rcv_nxt);
                end
            end
            tcsm_pkg::ACT_LISTEN:
            begin
                if (st == tcsm_pkg::ST_CLOSED)
                begin
                    m_iss = it.initial_seq;
                    m_state = tcsm_pkg::ST_LISTEN;
                end
            end
            tcsm_pkg::ACT_CLOSE:
            begin
                if (st == tcsm_pkg::ST_LISTEN || st == tcsm_pkg::ST_SYN_SENT)
                begin
                    m_state = tcsm_pkg::ST_CLOSED;
                    ev = tcsm_pkg::EV_RELEASED;
                end
                else if (st == tcsm_pkg::ST_SYN_RCVD || st == tcsm_pkg::ST_ESTAB ||
                         st == tcsm_pkg::ST_CLOSE_WAIT)
                begin
                    push_seg(tcsm_pkg::FL_FIN | tcsm_pkg::FL_ACK, m_snd_nxt, m_rcv_nxt);
                    m_snd_nxt++;
                    m_state = (st == tcsm_pkg::ST_CLOSE_WAIT) ? tcsm_pkg::ST_LAST_ACK
                                                              : tcsm_pkg::ST_FIN_WAIT_1;
                end
            end
            tcsm_pkg::ACT_ABORT:
            begin
                if (st == tcsm_pkg::ST_SYN_RCVD || st == tcsm_pkg::ST_ESTAB ||
                    st == tcsm_pkg::ST_FIN_WAIT_1 || st == tcsm_pkg::ST_FIN_WAIT_2 ||
                    st == tcsm_pkg::ST_CLOSE_WAIT)
                    push_seg(tcsm_pkg::FL_RST, m_snd_nxt, m_rcv_nxt);
                if (st != tcsm_pkg::ST_CLOSED)
                    ev = tcsm_pkg::EV_RELEASED;
                m_state = tcsm_pkg::ST_CLOSED;
            end
            default: ;
        endcase
        nres = (n_tx == 0) ? 1 : n_tx;
        for (int k = 0; k < nres; k++)
        begin
            r.send_valid      = (k < n_tx);
            r.send_flags      = (k < n_tx) ? tx_fl[k] : 6'd0;
            r.send_seq        = (k < n_tx) ? tx_sq[k] : 32'd0;
            r.send_ack        = (k < n_tx) ? tx_ak[k] : 32'd0;
            r.conn_status     = m_state;
            r.event_code      = ev;
            r.accept_payload  = acc;
            r.peer_window_out = m_win;
            r.last_result     = (k + 1 == nres);
            expected_words.push_back(r);
        end
    endtask

    // Stimulus builders ------------------------------------------------------

    function automatic tcsm_pkg::item_t blank_item(logic [2:0] act);
        tcsm_pkg::item_t it;
        it = '0;
        it.action        = act;
        it.checksum_ok   = 1;
        it.rx_space_free = 16'hFFFF;
        return it;
    endfunction

    function automatic tcsm_pkg::item_t rand_item();
        tcsm_pkg::item_t it;
        logic [191:0]    raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(tcsm_pkg::item_t)-1:0];
        it.action = 3'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic tcsm_pkg::item_t seg_item(logic [5:0] fl, logic [31:0] sq,
                                                 logic [31:0] ak);
        tcsm_pkg::item_t it;
        it = blank_item(tcsm_pkg::ACT_SEGMENT);
        it.seg_flags     = fl;
        it.seg_seq       = sq;
        it.seg_ack       = ak;
        it.seg_window    = 16'($urandom);
        it.rx_space_free = 16'($urandom);
        it.rx_pending    = 1'($urandom);
        it.payload_len   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 40));
        if ($urandom_range(0, 3) == 0)
            it.seg_flags |= 6'($urandom) & 6'h28;
        return it;
    endfunction

    // Queue a well-formed session with random content, tracking the peer side.
    task automatic add_session();
        logic [31:0]     our, peer, prx;
        tcsm_pkg::item_t it;
        int              n;
        our  = $urandom;
        peer = $urandom;
        it = blank_item(($urandom_range(0, 1) != 0) ? tcsm_pkg::ACT_OPEN
                                                    : tcsm_pkg::ACT_LISTEN);
        it.initial_seq = our;
        pending_items.push_back(it);
        if (it.action == tcsm_pkg::ACT_OPEN)
            pending_items.push_back(seg_item(tcsm_pkg::FL_SYN | tcsm_pkg::FL_ACK,
                                             peer, our + 1));
        else
        begin
            pending_items.push_back(seg_item(tcsm_pkg::FL_SYN, peer, 32'd0));
            pending_items.push_back(seg_item(tcsm_pkg::FL_ACK, peer + 1, our + 1));
        end
        // Payloads may be refused, so the peer sequence is a guess; mostly
        // guess well, sometimes off by one.
        prx = peer + 1;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            it = seg_item(tcsm_pkg::FL_ACK |
                          (($urandom_range(0, 4) == 0) ? tcsm_pkg::FL_FIN : 6'd0),
                          prx, our + 1 + 32'($urandom_range(0, 1)));
            if ($urandom_range(0, 6) == 0)
                it.seg_seq = it.seg_seq + 1;
            if ($urandom_range(0, 12) == 0)
                it.seg_flags |= tcsm_pkg::FL_RST;
            if ($urandom_range(0, 15) == 0)
                it.checksum_ok = 0;
            if (it.payload_len <= it.rx_space_free)
                prx = prx + 32'(it.payload_len)
                    + (((it.seg_flags & tcsm_pkg::FL_FIN) != 0) ? 1 : 0);
            pending_items.push_back(it);
        end
        pending_items.push_back(blank_item(tcsm_pkg::ACT_CLOSE));
        it = seg_item(tcsm_pkg::FL_ACK |
                      (($urandom_range(0, 1) != 0) ? tcsm_pkg::FL_FIN : 6'd0),
                      prx, our + 2);
        it.payload_len = 0;
        pending_items.push_back(it);
        if ($urandom_range(0, 1) != 0)
            pending_items.push_back(blank_item(tcsm_pkg::ACT_ABORT));
        if ($urandom_range(0, 3) == 0)
            pending_items.push_back(rand_item());
        pending_items.push_back(blank_item(tcsm_pkg::ACT_ABORT));
    endtask

    // Driver: present one word at a time, change inputs at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_ready_seen)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    item       <= pending_items[0];
                    item_valid <= 1'b1;
                    void'(pending_items.pop_front());
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver: random ready, with one long hold-off counted here.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                result_ready <= 1'b0;
                hold_off <= hold_off - 1;
            end
            else if (hold_req && !hold_done)
            begin
                result_ready <= 1'b0;
                hold_off <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else
                result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Monitor: sample handshakes at the rising edge.
    always @(posedge clk)
    begin
        item_ready_seen <= 1'b0;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (item_valid && item_ready)
            begin
                predict_step(item);
                item_ready_seen <= 1'b1;
            end
            if (result_valid && result_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word %p", $realtime, result);
                    errors++;
                end
                else
                begin
                    if (result !== expected_words[0])
                    begin
                        $display("%0t: mismatch expected %p", $realtime, expected_words[0]);
                        $display("%0t:          actual   %p", $realtime, result);
                        errors++;
                    end
                    void'(expected_words.pop_front());
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        tcsm_pkg::item_t it;
        clk = 0;
        rst_n = 0;
        item_valid = 0;
        item = '0;
        result_ready = 0;
        errors = 0;
        cycles = 0;
        item_ready_seen = 0;
        sender_idle_pct = 24;
        receiver_idle_pct = 55;

        // Directed: closed-state replies, every command, field extremes.
        pending_items.push_back(seg_item(tcsm_pkg::FL_SYN, 32'hFFFF_FFFF, 32'd0));
        pending_items.push_back(seg_item(tcsm_pkg::FL_ACK, 32'd0, 32'hFFFF_FFFF));
        pending_items.push_back(seg_item(tcsm_pkg::FL_RST, 32'd5, 32'd6));
        it = seg_item(6'h3F, 32'd1, 32'd2);
        it.checksum_ok = 0;
        pending_items.push_back(it);
        pending_items.push_back(blank_item(tcsm_pkg::ACT_CLOSE));
        pending_items.push_back(blank_item(tcsm_pkg::ACT_ABORT));
        pending_items.push_back(blank_item(3'd7));
        it = blank_item(tcsm_pkg::ACT_OPEN);
        it.initial_seq = 32'hFFFF_FFFF;
        pending_items.push_back(it);
        pending_items.push_back(blank_item(tcsm_pkg::ACT_LISTEN));
        pending_items.push_back(seg_item(tcsm_pkg::FL_RST, 32'd0, 32'd0));
        pending_items.push_back(blank_item(tcsm_pkg::ACT_LISTEN));
        pending_items.push_back(blank_item(tcsm_pkg::ACT_CLOSE));
        pending_items.push_back(blank_item(tcsm_pkg::ACT_LISTEN));
        it = seg_item(tcsm_pkg::FL_SYN, 32'hFFFF_FFFF, 32'd0);
        it.seg_window = 16'hFFFF;
        pending_items.push_back(it);
        pending_items.push_back(seg_item(tcsm_pkg::FL_RST, 32'd0, 32'd0));
        pending_items.push_back(seg_item(tcsm_pkg::FL_SYN, 32'd100, 32'd0));
        it = seg_item(tcsm_pkg::FL_ACK, 32'd101, 32'd1);
        it.payload_len = 16'hFFFF;
        it.rx_space_free = 16'hFFFE;
        pending_items.push_back(it);
        pending_items.push_back(seg_item(tcsm_pkg::FL_ACK, 32'd50, 32'd1));
        pending_items.push_back(blank_item(tcsm_pkg::ACT_ABORT));

        while (pending_items.size() < 140)
            add_session();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        wait (pending_items.size() == 0);
        sender_idle_pct = 55;
        receiver_idle_pct = 24;
        hold_req = 1'b1;
        while (pending_items.size() < 140)
        begin
            if ($urandom_range(0, 4) == 0)
                pending_items.push_back(rand_item());
            else
                add_session();
        end
        wait (pending_items.size() == 0);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        while (pending_items.size() < 140)
            add_session();
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (item_valid && !item_ready_seen)
            @(posedge clk);
        wait (expected_words.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tcsm_pkg.sv
hw/rtl/tcsm_step.sv
hw/rtl/tcp_connection_state_machine.sv
bench/tcp_connection_state_machine_tb.sv
